FILE: hw/rtl/rme_pkg.sv
package rme_pkg;

    localparam int WORD_BITS = 31;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;
    // multiplier sum width: 2*acc + a stays below 3m < 2^33
    localparam int EXT_BITS  = WORD_BITS + 2;

    // register word index, taken from paddr[2]
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    localparam logic [WORD_BITS-1:0] MODULUS_RESET  = WORD_BITS'(2);
    localparam logic [WORD_BITS-1:0] EXPONENT_RESET = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] ONE_WORD       = WORD_BITS'(1);

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_ACCMUL,
        S_SQUARE,
        S_DONE
    } rme_state_t;

endpackage

FILE: hw/rtl/rsa_modular_exponentiation_unit.sv
// Modular exponentiation unit: plaintext = ciphertext ^ private_exponent mod modulus.
//
// Input channel (in_valid / in_stall / ciphertext) takes one 31-bit word when
// in_valid is high and in_stall is low. in_stall stays high while a word is
// being worked on; the unit handles one word at a time.
// Output channel (out_valid / out_stall / plaintext) holds its word in an
// output register until out_stall is low, so a new input word can be taken
// while an earlier result still waits there.
// Registers are set over the APB-style port: modulus at byte address 0,
// private_exponent at byte address 4. Write them only while the unit is idle.
// The unit uses one shared bit-serial modular multiplier: the ciphertext is
// first reduced modulo the modulus (one pass), then right-to-left
// square-and-multiply runs over the exponent bits, taking k products (set bits
// plus bit length minus one, at most 61).
// A modulus below 2 returns 0 without running the multiplier; an exponent of
// zero returns 1.
// Reset sets modulus to 2, private_exponent to 1 and empties the output.
module rsa_modular_exponentiation_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rme_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [rme_pkg::DATA_BITS-1:0]     pwdata,
    output logic [rme_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rme_pkg::WORD_BITS-1:0]     ciphertext,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rme_pkg::WORD_BITS-1:0]     plaintext
);
    import rme_pkg::*;

    rme_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] exponent_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [CNT_BITS-1:0]  mul_cnt_reg, mul_cnt_next;

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] sq_reg, sq_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] mul_a_reg, mul_a_next;
    logic [WORD_BITS-1:0] mul_b_reg, mul_b_next;
    logic [WORD_BITS-1:0] mul_acc_reg, mul_acc_next;
    logic [WORD_BITS-1:0] plaintext_reg, plaintext_next;

    logic                 cfg_write;
    logic [EXT_BITS-1:0]  mul_sum;
    logic [EXT_BITS-1:0]  mod_1x;
    logic [EXT_BITS-1:0]  mod_2x;
    logic [WORD_BITS-1:0] mul_res;
    logic                 mul_last;
    logic                 mul_busy;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_MODULUS:  prdata = {{(DATA_BITS-WORD_BITS){1'b0}}, modulus_reg};
            REG_EXPONENT: prdata = {{(DATA_BITS-WORD_BITS){1'b0}}, exponent_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MODULUS:  modulus_reg  <= pwdata[WORD_BITS-1:0];
                REG_EXPONENT: exponent_reg <= pwdata[WORD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Shared modular multiplier: one multiplier bit per cycle, MSB first.
    // acc <- (2*acc + bit*a) mod m; with acc, a < m the sum is below 3m,
    // so at most two subtractions of m are needed.
    // ---------------------------------------------------------------
    assign mul_sum = {1'b0, mul_acc_reg, 1'b0}
                   + (mul_b_reg[WORD_BITS-1] ? {2'b00, mul_a_reg} : '0);
    assign mod_1x  = {2'b00, modulus_reg};
    assign mod_2x  = {1'b0, modulus_reg, 1'b0};

    always_comb
    begin
        logic [EXT_BITS-1:0] diff;
        diff = mul_sum;
        if (mul_sum >= mod_2x)
            diff = mul_sum - mod_2x;
        else if (mul_sum >= mod_1x)
            diff = mul_sum - mod_1x;
        mul_res = diff[WORD_BITS-1:0];
    end

    assign mul_last = (mul_cnt_reg == CNT_LAST);
    assign mul_busy = (state_reg == S_REDUCE) || (state_reg == S_ACCMUL)
                   || (state_reg == S_SQUARE);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mul_cnt_next   = mul_cnt_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_acc_next   = mul_acc_reg;
        plaintext_next = plaintext_reg;

        // drop the output word once the receiver takes it
        out_valid_next = out_valid_reg & out_stall;

        if (mul_busy)
        begin
            mul_acc_next = mul_res;
            mul_b_next   = {mul_b_reg[WORD_BITS-2:0], 1'b0};
            mul_cnt_next = mul_last ? '0 : mul_cnt_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (modulus_reg < MODULUS_RESET)
                    begin
                        // modulus of 0 or 1: every residue is 0
                        acc_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // reduce the base as 1 * ciphertext mod m
                        mul_a_next   = ONE_WORD;
                        mul_b_next   = ciphertext;
                        mul_acc_next = '0;
                        acc_next     = ONE_WORD;
                        exp_next     = exponent_reg;
                        state_next   = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mul_last)
                begin
                    sq_next    = mul_res;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                mul_acc_next = '0;
                if (exp_reg == '0)
                    state_next = S_DONE;
                else if (exp_reg[0])
                begin
                    mul_a_next = acc_reg;
                    mul_b_next = sq_reg;
                    exp_next   = {exp_reg[WORD_BITS-1:1], 1'b0};
                    state_next = S_ACCMUL;
                end
                else
                begin
                    mul_a_next = sq_reg;
                    mul_b_next = sq_reg;
                    exp_next   = {1'b0, exp_reg[WORD_BITS-1:1]};
                    state_next = S_SQUARE;
                end
            end
            S_ACCMUL:
            begin
                if (mul_last)
                begin
                    acc_next   = mul_res;
                    state_next = S_CHECK;
                end
            end
            S_SQUARE:
            begin
                if (mul_last)
                begin
                    sq_next    = mul_res;
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    plaintext_next = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mul_cnt_reg   <= mul_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        sq_reg        <= sq_next;
        exp_reg       <= exp_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        mul_acc_reg   <= mul_acc_next;
        plaintext_reg <= plaintext_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign plaintext = plaintext_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_mul_residue: assert property (@(posedge clk) disable iff (!rst_n)
        mul_busy |-> (mul_acc_reg < modulus_reg) && (mul_a_reg < modulus_reg))
        else $error("multiplier operand or partial result not reduced");

    a_check_residue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (acc_reg < modulus_reg) && (sq_reg < modulus_reg))
        else $error("accumulator or square not reduced");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !mul_busy |-> (mul_cnt_reg == '0))
        else $error("bit counter left running outside a product");

    a_mul_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_busy && mul_last) |=> (state_reg == S_CHECK))
        else $error("product finished without returning to the check step");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (plaintext_reg < modulus_reg) || (plaintext_reg == '0))
        else $error("output word not below the modulus");

endmodule

FILE: verif/testbench.sv
module testbench;
    import rme_pkg::*;

    // Clock half period in simulation time units, and the reset length in cycles of clk.
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    // The settle and hold lengths, in cycles of clk, each outlast the slowest word.
    localparam int SETTLE_CYCLES = 2100;
    localparam int HOLD_CYCLES   = 6000;
    // Start the long receiver hold partway into the first random phase.
    localparam int HOLD_AT       = 40;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_WORDS   = 30;
    localparam longint LIMIT_CYCLES = 4_000_000;

    localparam logic [WORD_BITS-1:0] WORD_MAX = '1;

    // Every input of the block starts at a known value.
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [ADDR_BITS-1:0] paddr      = '0;
    logic [DATA_BITS-1:0] pwdata     = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [WORD_BITS-1:0] ciphertext = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [WORD_BITS-1:0] plaintext;

    // Testbench copy of the two registers, updated when an APB write commits.
    logic [WORD_BITS-1:0] cur_modulus  = MODULUS_RESET;
    logic [WORD_BITS-1:0] cur_exponent = EXPONENT_RESET;

    // Ciphertext words waiting to be offered, and plaintext words owed by the block.
    logic [WORD_BITS-1:0] cipher_backlog[$];
    logic [WORD_BITS-1:0] plaintext_due[$];

    int   words_queued   = 0;
    int   words_accepted = 0;
    int   err_count      = 0;
    int   send_gap       = 0;
    int   stall_left     = 0;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;
    bit   send_idle_en   = 1'b1;
    bit   recv_idle_en   = 1'b1;
    logic [WORD_BITS-1:0] want;

    rsa_modular_exponentiation_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ciphertext (ciphertext),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plaintext  (plaintext)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Right-to-left square-and-multiply over the exponent bits up to the top set bit.
    // A modulus below 2 leaves nothing to reduce into, so the answer is zero.
    // All residues stay below 2^31, so every product fits in 64 bits.
    function automatic logic [WORD_BITS-1:0] modexp_plaintext(
        input logic [WORD_BITS-1:0] base,
        input logic [WORD_BITS-1:0] modulus,
        input logic [WORD_BITS-1:0] exponent
    );
        logic [63:0] m64;
        logic [63:0] acc;
        logic [63:0] sq;
        int          i;
        m64 = 64'(modulus);
        if (m64 < 64'd2)
            return '0;
        acc = 64'd1;
        sq  = 64'(base) % m64;
        for (i = 0; i < WORD_BITS; i++)
        begin
            if ((exponent >> i) == '0)
                break;
            if (i != 0)
                sq = (sq * sq) % m64;
            if (exponent[i])
                acc = (acc * sq) % m64;
        end
        return acc[WORD_BITS-1:0];
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 250);
    endfunction

    // Driver: offer the next ciphertext word once the current one is taken.
    // Hold the payload steady while the block stalls; drop valid only after acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                // Predict at acceptance, under the settings the block holds right now.
                plaintext_due.insert(plaintext_due.size(),
                                     modexp_plaintext(ciphertext, cur_modulus,
                                                      cur_exponent));
                words_accepted <= words_accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cipher_backlog.size() != 0)
                begin
                    in_valid   <= 1'b1;
                    ciphertext <= cipher_backlog.pop_front();
                    send_gap   <= send_idle_en ? draw_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once: the block fills up and must stall its input
    // while the driver keeps offering words.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && words_accepted == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver stall: random stretches, forced high during the long hold.
    always @(posedge clk)
    begin
        int g;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            g = recv_idle_en ? draw_gap() : 0;
            out_stall  <= (g != 0);
            stall_left <= (g != 0) ? g - 1 : 0;
        end
    end

    // Monitor: compare each accepted plaintext word against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (plaintext_due.size() == 0)
            begin
                $error("plaintext: no word owed, actual %h", plaintext);
                err_count++;
            end
            else
            begin
                want = plaintext_due.pop_front();
                if (plaintext !== want)
                begin
                    $error("plaintext: expected %h, actual %h", want, plaintext);
                    err_count++;
                end
            end
        end
    end

    // APB write: setup cycle, then access cycle; the register takes the value at
    // the edge where psel, penable, pwrite and pready are all high.
    task automatic reg_write(input logic idx, input logic [DATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Bits above the word width are dropped by the block.
        if (idx == REG_MODULUS)
            cur_modulus = data[WORD_BITS-1:0];
        else
            cur_exponent = data[WORD_BITS-1:0];
    endtask

    task automatic set_config(input logic [DATA_BITS-1:0] mod_w,
                              input logic [DATA_BITS-1:0] exp_w);
        reg_write(REG_MODULUS, mod_w);
        reg_write(REG_EXPONENT, exp_w);
    endtask

    task automatic queue_word(input logic [WORD_BITS-1:0] ct);
        cipher_backlog.insert(cipher_backlog.size(), ct);
        words_queued++;
    endtask

    // Wait until every queued word is taken and every plaintext has come back.
    // Sample on the falling edge so the counters and queues are settled.
    task automatic drain();
        do
            @(negedge clk);
        while (words_accepted != words_queued || plaintext_due.size() != 0);
    endtask

    initial
    begin
        logic [DATA_BITS-1:0] mod_w;
        logic [DATA_BITS-1:0] exp_w;
        logic [WORD_BITS-1:0] ct;
        int                   phase;
        int                   k;
        int                   sel;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: modulus 2, exponent 1.
        queue_word('0);
        queue_word(ONE_WORD);
        queue_word(WORD_MAX);
        queue_word(WORD_BITS'(5));
        drain();

        // Largest modulus and exponent, written with bit 31 set to check masking.
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word('0);
        queue_word(ONE_WORD);
        queue_word(WORD_BITS'(2));
        queue_word(WORD_MAX - 1);
        queue_word(WORD_MAX);
        drain();

        // Exponent zero answers one.
        set_config(32'd1_000_003, 32'd0);
        queue_word('0);
        queue_word(WORD_BITS'(12345));
        queue_word(WORD_MAX);
        drain();

        // Modulus one: every residue is zero.
        set_config(32'd1, 32'd5);
        queue_word(WORD_BITS'(9));
        queue_word(WORD_MAX);
        drain();

        // Modulus zero: no reduction possible, answer zero.
        set_config(32'd0, 32'd3);
        queue_word('0);
        queue_word(WORD_BITS'(77));
        drain();

        // Small modulus, exponent with only its top bit set; base below, at and above the modulus.
        set_config(32'd3, 32'h4000_0000);
        queue_word(WORD_BITS'(2));
        queue_word(WORD_BITS'(3));
        queue_word(WORD_BITS'(4));
        drain();

        // Random phases: fresh settings each time, some with idling switched off.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                mod_w = 32'h7FFF_FFFF;
            else if (sel == 1)
                mod_w = $urandom_range(2, 255);
            else if (sel == 2)
                mod_w = $urandom_range(0, 1);
            else
                mod_w = $urandom_range(2, 32'h7FFF_FFFF);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                exp_w = 32'd0;
            else if (sel == 1)
                exp_w = 32'h7FFF_FFFF;
            else if (sel < 6)
                exp_w = $urandom_range(1, 255);
            else
                exp_w = $urandom_range(1, 32'h7FFF_FFFF);
            // Flip the unused top bit at random; the block must ignore it.
            mod_w[31] = $urandom_range(0, 1);
            exp_w[31] = $urandom_range(0, 1);
            set_config(mod_w, exp_w);
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    ct = WORD_BITS'($urandom_range(0, 1));
                else if (sel == 1 && cur_modulus != '0)
                    ct = cur_modulus - ONE_WORD;
                else if (sel == 2 && cur_modulus != '0)
                    ct = WORD_BITS'($urandom % cur_modulus);
                else
                    ct = WORD_BITS'($urandom);
                queue_word(ct);
            end
            drain();
        end

        // Let any stray word show up before closing.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rme_pkg.sv
hw/rtl/rsa_modular_exponentiation_unit.sv
verif/testbench.sv
